// ===== rtl/ttrd_pkg.sv =====
// Shared types and codes for the timed task release dispatcher.
// No dependencies; used by ttrd_cell, the top level and the checker.
package ttrd_pkg;

  localparam int DUE_W   = 63;
  localparam int MASK_W  = 64;
  localparam int TAG_W   = 16;
  localparam int IN_DW   = 272;
  localparam int OUT_DW  = 152;

  // opcodes (in_tuser)
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;
  localparam logic [1:0] OP_ADVANCE  = 2'd3;

  // result kinds (out_tuser)
  localparam logic [1:0] KIND_DISPATCH = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  // register indexes
  localparam logic [2:0] REG_GROUP_COUNT = 3'd0;
  localparam logic [2:0] REG_KEY0        = 3'd1;
  localparam logic [2:0] REG_KEY1        = 3'd2;
  localparam logic [2:0] REG_KEY2        = 3'd3;
  localparam logic [2:0] REG_KEY3        = 3'd4;
  localparam logic [2:0] REG_MAX_STAGE   = 3'd5;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              wr;        // store new task in the selected cell
    logic              load_rot;  // start a ranking sweep, clear hits
    logic              cmp;       // one ranking step
    logic              mark;      // mark the selected cell as delivered
    logic              remove;    // drop delivered cells
    logic [DUE_W-1:0]  probe;     // due time under test / to store
    logic [DUE_W-1:0]  now;
    logic [MASK_W-1:0] key;
    logic [MASK_W-1:0] stage;
    logic [TAG_W-1:0]  new_tag;
    logic [MASK_W-1:0] new_where;
    logic [MASK_W-1:0] new_stage;
  } cell_ctl_t;

  // status from one cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             sel;     // valid and rank equals the scan rank
    logic             due_le;  // due <= now
    logic             match;   // affinity and stage match
    logic             taken;   // valid and due == probe
    logic [TAG_W-1:0] tag;
    logic [DUE_W-1:0] due;
  } cell_stat_t;

endpackage

// ===== rtl/ttrd_cell.sv =====
// One task slot of the dispatcher chain: holds a task, ranks it against
// the dues rotating past from its neighbor. Depends on ttrd_pkg.
module ttrd_cell #(
  parameter int RW = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ttrd_pkg::cell_ctl_t         ctl,
  input  logic                        wr_sel,
  input  logic [RW-1:0]               scan_rank,
  input  logic [ttrd_pkg::DUE_W-1:0]  rot_due_i,
  input  logic                        rot_v_i,
  output logic [ttrd_pkg::DUE_W-1:0]  rot_due_o,
  output logic                        rot_v_o,
  output ttrd_pkg::cell_stat_t        stat
);

  logic                         valid_r;
  logic                         hit_r;
  logic [ttrd_pkg::DUE_W-1:0]   due_r;
  logic [ttrd_pkg::MASK_W-1:0]  where_r;
  logic [ttrd_pkg::MASK_W-1:0]  stg_r;
  logic [ttrd_pkg::TAG_W-1:0]   tag_r;
  logic [ttrd_pkg::DUE_W-1:0]   rot_due_r;
  logic                         rot_v_r;
  logic [RW-1:0]                rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      rot_v_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      if (ctl.wr && wr_sel) begin
        valid_r <= 1'b1;
      end else if (ctl.remove && hit_r) begin
        valid_r <= 1'b0;
      end
      if (ctl.load_rot || ctl.remove) begin
        hit_r <= 1'b0;
      end else if (ctl.mark && stat.sel) begin
        hit_r <= 1'b1;
      end
      if (ctl.load_rot) begin
        rot_v_r <= valid_r;
        rank_r  <= '0;
      end else if (ctl.cmp) begin
        rot_v_r <= rot_v_i;
        if (rot_v_i && valid_r && (rot_due_i < due_r)) begin
          rank_r <= rank_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && wr_sel) begin
      due_r   <= ctl.probe;
      where_r <= ctl.new_where;
      stg_r   <= ctl.new_stage;
      tag_r   <= ctl.new_tag;
    end
    if (ctl.load_rot) begin
      rot_due_r <= due_r;
    end else if (ctl.cmp) begin
      rot_due_r <= rot_due_i;
    end
  end

  assign rot_due_o = rot_due_r;
  assign rot_v_o   = rot_v_r;

  always_comb begin
    stat.valid  = valid_r;
    stat.hit    = hit_r;
    stat.sel    = valid_r && (rank_r == scan_rank);
    stat.due_le = (due_r <= ctl.now);
    // a zero current stage passes every task on the stage check
    stat.match  = ((where_r == '0) || ((where_r & ctl.key) != '0)) &&
                  ((ctl.stage == '0) || (stg_r == '0) || ((stg_r & ctl.stage) != '0));
    stat.taken  = valid_r && (due_r == ctl.probe);
    stat.tag    = tag_r;
    stat.due    = due_r;
  end

endmodule

// ===== rtl/timed_task_release_dispatcher.sv =====
// Timed task release dispatcher, top level: sequencer, config port and
// output register around a chain of ttrd_cell slots. Depends on ttrd_pkg.
//
// One item is handled at a time. Start and advance go straight to the send
// state. An insert steps its due time once per bump (at most QUEUE_DEPTH-1
// bumps) and then stores it, or reports full when the table is full. A
// dispatch first ranks the slots by rotating every due time once around the
// cell chain, then walks the ranks once per group to mark deliveries, walks
// the ranks for the earliest remaining due, and then either sends a single
// none result when nothing was marked, or walks the groups again to send one
// item per delivery and finally drops delivered slots. Result stalls hold
// the send steps. Results go through a single output register, so the next
// item may be accepted while the last result still waits.
module timed_task_release_dispatcher #(
  parameter int QUEUE_DEPTH = 8,
  parameter int GROUPS      = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: task_tag[15:0], due_time[78:16], where_mask[142:79],
  //           stage_mask[206:143], now_time[269:207], zero pad [271:270]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ttrd_pkg::IN_DW-1:0]    in_tdata,
  input  logic [1:0]                    in_tuser,   // opcode[1:0]
  // out_tdata: out_tag[15:0], group_index[17:16], stage_done[81:18],
  //            next_due[144:82], has_next[145], zero pad [151:146]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ttrd_pkg::OUT_DW-1:0]   out_tdata,
  output logic [1:0]                    out_tuser,  // kind[1:0]
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [5:0]                    cfg_paddr,
  input  logic [63:0]                   cfg_pwdata,
  output logic [63:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int RW = $clog2(QUEUE_DEPTH);
  localparam int SW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = $clog2(GROUPS * QUEUE_DEPTH + 1);
  localparam int DW = ttrd_pkg::DUE_W;
  localparam int MW = ttrd_pkg::MASK_W;
  localparam int TW = ttrd_pkg::TAG_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BUMP   = 3'd1;
  localparam logic [2:0] ST_RANK   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_NEXT   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;
  localparam logic [2:0] ST_REMOVE = 3'd6;
  localparam logic [2:0] ST_SEND   = 3'd7;

  // input fields
  logic [TW-1:0] f_tag;
  logic [DW-1:0] f_due;
  logic [MW-1:0] f_where;
  logic [MW-1:0] f_stage;
  logic [DW-1:0] f_now;
  assign f_tag   = in_tdata[15:0];
  assign f_due   = in_tdata[78:16];
  assign f_where = in_tdata[142:79];
  assign f_stage = in_tdata[206:143];
  assign f_now   = in_tdata[269:207];

  // configuration
  logic [2:0]    gcnt_r;
  logic [MW-1:0] key_r [4];
  logic [MW-1:0] maxs_r;
  logic [2:0]    gc_eff;

  assign cfg_pready = 1'b1;
  assign gc_eff = (gcnt_r > 3'(GROUPS)) ? 3'(GROUPS) : gcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r   <= 3'd1;
      key_r[0] <= '0;
      key_r[1] <= '0;
      key_r[2] <= '0;
      key_r[3] <= '0;
      maxs_r   <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[5:3])
        ttrd_pkg::REG_GROUP_COUNT: gcnt_r   <= cfg_pwdata[2:0];
        ttrd_pkg::REG_KEY0:        key_r[0] <= cfg_pwdata;
        ttrd_pkg::REG_KEY1:        key_r[1] <= cfg_pwdata;
        ttrd_pkg::REG_KEY2:        key_r[2] <= cfg_pwdata;
        ttrd_pkg::REG_KEY3:        key_r[3] <= cfg_pwdata;
        ttrd_pkg::REG_MAX_STAGE:   maxs_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[5:3])
      ttrd_pkg::REG_GROUP_COUNT: cfg_prdata = {61'd0, gcnt_r};
      ttrd_pkg::REG_KEY0:        cfg_prdata = key_r[0];
      ttrd_pkg::REG_KEY1:        cfg_prdata = key_r[1];
      ttrd_pkg::REG_KEY2:        cfg_prdata = key_r[2];
      ttrd_pkg::REG_KEY3:        cfg_prdata = key_r[3];
      ttrd_pkg::REG_MAX_STAGE:   cfg_prdata = maxs_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  // sequencer registers
  logic [2:0]    state_r, state_nxt;
  logic [DW-1:0] probe_r, probe_nxt;
  logic [DW-1:0] now_r, now_nxt;
  logic [TW-1:0] ntag_r, ntag_nxt;
  logic [MW-1:0] nwhere_r, nwhere_nxt;
  logic [MW-1:0] nstage_r, nstage_nxt;
  logic [RW-1:0] free_r, free_nxt;
  logic [RW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic [SW-1:0] n_r, n_nxt;
  logic [2:0]    grp_r, grp_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] ek_r, ek_nxt;
  logic [DW-1:0] nd_r, nd_nxt;
  logic          hn_r, hn_nxt;
  logic [MW-1:0] cs_r, cs_nxt;
  logic [1:0]    pkind_r, pkind_nxt;
  logic [MW-1:0] psd_r, psd_nxt;

  // output register
  logic          ov_r;
  logic [1:0]    okind_r;
  logic [TW-1:0] otag_r;
  logic [1:0]    ogrp_r;
  logic [MW-1:0] osd_r;
  logic [DW-1:0] ond_r;
  logic          ohn_r;
  logic          olast_r;
  logic          out_free;
  logic          ld;
  logic [1:0]    ld_kind;
  logic [TW-1:0] ld_tag;
  logic [1:0]    ld_grp;
  logic [MW-1:0] ld_sd;
  logic [DW-1:0] ld_nd;
  logic          ld_hn;
  logic          ld_last;

  // cell chain
  ttrd_pkg::cell_ctl_t  ctl;
  ttrd_pkg::cell_stat_t stat [QUEUE_DEPTH];
  logic [DW-1:0]        rot_due [QUEUE_DEPTH];
  logic                 rot_v   [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ttrd_cell #(.RW(RW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr_sel    (free_r == RW'(i)),
      .scan_rank (scan_r[RW-1:0]),
      .rot_due_i (rot_due[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
      .rot_v_i   (rot_v[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
      .rot_due_o (rot_due[i]),
      .rot_v_o   (rot_v[i]),
      .stat      (stat[i])
    );
  end

  // gather from the chain: selected slot (one-hot by rank), free slot, counts
  logic          s_due_le, s_match, s_hit;
  logic [TW-1:0] s_tag;
  logic [DW-1:0] s_due;
  logic          any_taken;
  logic          all_valid;
  logic [RW-1:0] free_idx;
  logic [SW-1:0] nvalid;

  always_comb begin
    s_due_le  = 1'b0;
    s_match   = 1'b0;
    s_hit     = 1'b0;
    s_tag     = '0;
    s_due     = '0;
    any_taken = 1'b0;
    all_valid = 1'b1;
    free_idx  = '0;
    nvalid    = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (stat[i].sel) begin
        s_due_le = s_due_le | stat[i].due_le;
        s_match  = s_match  | stat[i].match;
        s_hit    = s_hit    | stat[i].hit;
        s_tag    = s_tag    | stat[i].tag;
        s_due    = s_due    | stat[i].due;
      end
      any_taken = any_taken | stat[i].taken;
      all_valid = all_valid & stat[i].valid;
      if (!stat[i].valid) begin
        free_idx = RW'(i);
      end
      nvalid = nvalid + SW'(stat[i].valid);
    end
  end

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  logic [MW-1:0] dbl;
  assign dbl = {cs_r[MW-2:0], 1'b0};

  always_comb begin
    state_nxt  = state_r;
    probe_nxt  = probe_r;
    now_nxt    = now_r;
    ntag_nxt   = ntag_r;
    nwhere_nxt = nwhere_r;
    nstage_nxt = nstage_r;
    free_nxt   = free_r;
    cnt_nxt    = cnt_r;
    scan_nxt   = scan_r;
    n_nxt      = n_r;
    grp_nxt    = grp_r;
    k_nxt      = k_r;
    ek_nxt     = ek_r;
    nd_nxt     = nd_r;
    hn_nxt     = hn_r;
    cs_nxt     = cs_r;
    pkind_nxt  = pkind_r;
    psd_nxt    = psd_r;

    ctl.wr        = 1'b0;
    ctl.load_rot  = 1'b0;
    ctl.cmp       = 1'b0;
    ctl.mark      = 1'b0;
    ctl.remove    = 1'b0;
    ctl.probe     = probe_r;
    ctl.now       = now_r;
    ctl.key       = key_r[grp_r[1:0]];
    ctl.stage     = cs_r;
    ctl.new_tag   = ntag_r;
    ctl.new_where = nwhere_r;
    ctl.new_stage = nstage_r;

    ld      = 1'b0;
    ld_kind = pkind_r;
    ld_tag  = '0;
    ld_grp  = '0;
    ld_sd   = psd_r;
    ld_nd   = nd_r;
    ld_hn   = hn_r;
    ld_last = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          psd_nxt = '0;
          nd_nxt  = '0;
          hn_nxt  = 1'b0;
          case (in_tuser)
            ttrd_pkg::OP_INSERT: begin
              if (all_valid) begin
                pkind_nxt = ttrd_pkg::KIND_FULL;
                state_nxt = ST_SEND;
              end else begin
                free_nxt   = free_idx;
                probe_nxt  = f_due;
                ntag_nxt   = f_tag;
                nwhere_nxt = f_where;
                nstage_nxt = f_stage;
                state_nxt  = ST_BUMP;
              end
            end
            ttrd_pkg::OP_DISPATCH: begin
              now_nxt      = f_now;
              ctl.load_rot = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = ST_RANK;
            end
            ttrd_pkg::OP_START: begin
              cs_nxt    = (maxs_r != '0) ? MW'(1) : '0;
              pkind_nxt = ttrd_pkg::KIND_DONE;
              state_nxt = ST_SEND;
            end
            ttrd_pkg::OP_ADVANCE: begin
              cs_nxt    = (dbl > maxs_r) ? MW'(1) : dbl;
              psd_nxt   = cs_r;
              pkind_nxt = ttrd_pkg::KIND_DONE;
              state_nxt = ST_SEND;
            end
            default: ;
          endcase
        end
      end

      // step the due time until no slot holds it, then store
      ST_BUMP: begin
        if (any_taken) begin
          probe_nxt = probe_r + DW'(1);
        end else begin
          ctl.wr    = 1'b1;
          pkind_nxt = ttrd_pkg::KIND_DONE;
          state_nxt = ST_SEND;
        end
      end

      ST_RANK: begin
        ctl.cmp = 1'b1;
        cnt_nxt = cnt_r + RW'(1);
        if (cnt_r == RW'(QUEUE_DEPTH - 1)) begin
          n_nxt     = nvalid;
          grp_nxt   = '0;
          scan_nxt  = '0;
          k_nxt     = '0;
          state_nxt = ST_SCAN;
        end
      end

      // first pass: mark deliveries in due order per group
      ST_SCAN: begin
        if (grp_r >= gc_eff) begin
          scan_nxt  = '0;
          state_nxt = ST_NEXT;
        end else if ((scan_r == n_r) || !s_due_le) begin
          grp_nxt  = grp_r + 3'd1;
          scan_nxt = '0;
        end else begin
          if (s_match) begin
            ctl.mark = 1'b1;
            k_nxt    = k_r + KW'(1);
          end
          scan_nxt = scan_r + SW'(1);
        end
      end

      // earliest slot that survives the removal
      ST_NEXT: begin
        if ((scan_r == n_r) || !s_hit) begin
          if (scan_r == n_r) begin
            nd_nxt = '0;
            hn_nxt = 1'b0;
          end else begin
            nd_nxt = s_due;
            hn_nxt = 1'b1;
          end
          grp_nxt  = '0;
          scan_nxt = '0;
          ek_nxt   = '0;
          if (k_r == '0) begin
            pkind_nxt = ttrd_pkg::KIND_NONE;
            state_nxt = ST_SEND;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end

      // second pass: same walk, one result per delivery
      ST_EMIT: begin
        if (grp_r >= gc_eff) begin
          state_nxt = ST_REMOVE;
        end else if ((scan_r == n_r) || !s_due_le) begin
          grp_nxt  = grp_r + 3'd1;
          scan_nxt = '0;
        end else if (s_match) begin
          if (out_free) begin
            ld       = 1'b1;
            ld_kind  = ttrd_pkg::KIND_DISPATCH;
            ld_tag   = s_tag;
            ld_grp   = grp_r[1:0];
            ld_sd    = '0;
            ld_last  = (ek_r == k_r - KW'(1));
            ek_nxt   = ek_r + KW'(1);
            scan_nxt = scan_r + SW'(1);
          end
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end

      ST_REMOVE: begin
        ctl.remove = 1'b1;
        state_nxt  = ST_IDLE;
      end

      ST_SEND: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cs_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cs_r    <= cs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r  <= probe_nxt;
    now_r    <= now_nxt;
    ntag_r   <= ntag_nxt;
    nwhere_r <= nwhere_nxt;
    nstage_r <= nstage_nxt;
    free_r   <= free_nxt;
    cnt_r    <= cnt_nxt;
    scan_r   <= scan_nxt;
    n_r      <= n_nxt;
    grp_r    <= grp_nxt;
    k_r      <= k_nxt;
    ek_r     <= ek_nxt;
    nd_r     <= nd_nxt;
    hn_r     <= hn_nxt;
    pkind_r  <= pkind_nxt;
    psd_r    <= psd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ld) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      okind_r <= ld_kind;
      otag_r  <= ld_tag;
      ogrp_r  <= ld_grp;
      osd_r   <= ld_sd;
      ond_r   <= ld_nd;
      ohn_r   <= ld_hn;
      olast_r <= ld_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, ohn_r, ond_r, osd_r, ogrp_r, otag_r};

endmodule

// ===== rtl/ttrd_checker.sv =====
// Port-level checks for timed_task_release_dispatcher, bound to the top.
// Depends on ttrd_pkg.
module ttrd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ttrd_pkg::OUT_DW-1:0] out_tdata,
  input logic [1:0]                  out_tuser,
  input logic                        out_tlast
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted back to back");

  // only dispatch deliveries come in runs
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ttrd_pkg::KIND_DISPATCH) |-> out_tlast)
    else $error("non-dispatch result without tlast");

  // non-dispatch results carry no tag or group
  a_notag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ttrd_pkg::KIND_DISPATCH) |-> out_tdata[17:0] == '0)
    else $error("tag on non-dispatch result");

endmodule

bind timed_task_release_dispatcher ttrd_checker u_ttrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/sv/ttrd_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the timed task release dispatcher: watches the config port,
// the input and result channels, predicts every result and compares it. Uses ttrd_pkg.
module ttrd_scoreboard #(
  parameter int DEPTH  = 8,
  parameter int NGROUP = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [ttrd_pkg::IN_DW-1:0]    in_tdata,
  input  logic [1:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [ttrd_pkg::OUT_DW-1:0]   out_tdata,
  input  logic [1:0]                    out_tuser,
  input  logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [5:0]                    cfg_paddr,
  input  logic [63:0]                   cfg_pwdata,
  input  logic                          cfg_pready,
  output int                            fail_count,
  output int                            pending
);

  typedef struct {
    logic [1:0]                  kind;
    logic [ttrd_pkg::TAG_W-1:0]  tag;
    logic [1:0]                  grp;
    logic [63:0]                 sdone;
    logic [ttrd_pkg::DUE_W-1:0]  nd;
    logic                        hn;
    logic                        last;
  } release_t;

  release_t expected_q[$];

  // predicted configuration and table
  logic [2:0]                  m_group_count;
  logic [63:0]                 m_key[NGROUP];
  logic [63:0]                 m_max_stage;
  logic [63:0]                 m_stage;
  logic                        s_valid[DEPTH];
  logic [ttrd_pkg::DUE_W-1:0]  s_due[DEPTH];
  logic [63:0]                 s_where[DEPTH];
  logic [63:0]                 s_stmask[DEPTH];
  logic [ttrd_pkg::TAG_W-1:0]  s_tag[DEPTH];

  function automatic release_t mk(logic [1:0] kind);
    release_t r;
    r.kind = kind; r.tag = '0; r.grp = '0; r.sdone = '0;
    r.nd = '0; r.hn = 1'b0; r.last = 1'b0;
    return r;
  endfunction

  function automatic bit due_busy(logic [ttrd_pkg::DUE_W-1:0] t);
    for (int i = 0; i < DEPTH; i++)
      if (s_valid[i] && s_due[i] == t) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_item(logic [1:0] op, logic [ttrd_pkg::IN_DW-1:0] d);
    logic [ttrd_pkg::TAG_W-1:0] tag;
    logic [ttrd_pkg::DUE_W-1:0] due, now, nd;
    logic [63:0] where_m, stage_m, old;
    int free_slot, n, ng, s, j, t;
    int order[DEPTH];
    bit hit[DEPTH];
    bit hn;
    release_t r, batch[$];
    tag = d[15:0]; due = d[78:16]; where_m = d[142:79];
    stage_m = d[206:143]; now = d[269:207];
    case (op)
      ttrd_pkg::OP_INSERT: begin
        free_slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--)
          if (!s_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          batch.push_back(mk(ttrd_pkg::KIND_FULL));
        end else begin
          while (due_busy(due)) due = due + 1'b1;  // wraps in 63 bits
          s_valid[free_slot] = 1'b1; s_due[free_slot] = due;
          s_where[free_slot] = where_m; s_stmask[free_slot] = stage_m;
          s_tag[free_slot] = tag;
          batch.push_back(mk(ttrd_pkg::KIND_DONE));
        end
      end
      ttrd_pkg::OP_DISPATCH: begin
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
          hit[i] = 1'b0;
          if (s_valid[i]) begin
            j = n;
            n = n + 1;
            while (j > 0 && s_due[order[j-1]] > s_due[i]) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = i;
          end
        end
        ng = (m_group_count > NGROUP) ? NGROUP : int'(m_group_count);
        for (int g = 0; g < ng; g++)
          for (j = 0; j < n; j++) begin
            s = order[j];
            if (s_due[s] > now) break;
            if (s_where[s] != 0 && (s_where[s] & m_key[g]) == 0) continue;
            if (m_stage != 0 && s_stmask[s] != 0 && (s_stmask[s] & m_stage) == 0)
              continue;
            hit[s] = 1'b1;
            r = mk(ttrd_pkg::KIND_DISPATCH); r.tag = s_tag[s]; r.grp = g[1:0];
            batch.push_back(r);
          end
        for (int i = 0; i < DEPTH; i++) if (hit[i]) s_valid[i] = 1'b0;
        hn = 1'b0; nd = '0;
        for (int i = 0; i < DEPTH; i++)
          if (s_valid[i] && (!hn || s_due[i] < nd)) begin
            nd = s_due[i]; hn = 1'b1;
          end
        if (batch.size() == 0) batch.push_back(mk(ttrd_pkg::KIND_NONE));
        foreach (batch[k]) begin
          batch[k].nd = nd; batch[k].hn = hn;
        end
      end
      ttrd_pkg::OP_START: begin
        m_stage = (m_max_stage != 0) ? 64'd1 : 64'd0;
        batch.push_back(mk(ttrd_pkg::KIND_DONE));
      end
      default: begin
        old = m_stage;
        m_stage = m_stage << 1;
        if (m_stage > m_max_stage) m_stage = 64'd1;
        r = mk(ttrd_pkg::KIND_DONE); r.sdone = old;
        batch.push_back(r);
      end
    endcase
    t = batch.size() - 1;
    batch[t].last = 1'b1;
    foreach (batch[k]) expected_q.push_back(batch[k]);
  endtask

  task automatic check_release();
    release_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result kind=%0d tag=%h", $time, out_tuser, out_tdata[15:0]);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (out_tuser !== e.kind || out_tdata[15:0] !== e.tag || out_tdata[17:16] !== e.grp ||
        out_tdata[81:18] !== e.sdone || out_tdata[144:82] !== e.nd ||
        out_tdata[145] !== e.hn || out_tlast !== e.last) begin
      $display("%0t: mismatch exp kind=%0d tag=%h grp=%0d sdone=%h nd=%h hn=%0d last=%0d",
               $time, e.kind, e.tag, e.grp, e.sdone, e.nd, e.hn, e.last);
      $display("%0t:          act kind=%0d tag=%h grp=%0d sdone=%h nd=%h hn=%0d last=%0d",
               $time, out_tuser, out_tdata[15:0], out_tdata[17:16], out_tdata[81:18],
               out_tdata[144:82], out_tdata[145], out_tlast);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      m_group_count = 3'd1;
      m_max_stage = '0;
      m_stage = '0;
      for (int i = 0; i < NGROUP; i++) m_key[i] = '0;
      for (int i = 0; i < DEPTH; i++) s_valid[i] = 1'b0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        case (cfg_paddr[5:3])
          ttrd_pkg::REG_GROUP_COUNT: m_group_count = cfg_pwdata[2:0];
          ttrd_pkg::REG_KEY0:        m_key[0] = cfg_pwdata;
          ttrd_pkg::REG_KEY1:        m_key[1] = cfg_pwdata;
          ttrd_pkg::REG_KEY2:        m_key[2] = cfg_pwdata;
          ttrd_pkg::REG_KEY3:        m_key[3] = cfg_pwdata;
          ttrd_pkg::REG_MAX_STAGE:   m_max_stage = cfg_pwdata;
          default: ;
        endcase
      if (out_tvalid && out_tready) check_release();
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/sv/tb_timed_task_release_dispatcher.sv =====
`timescale 1ns / 1ps
// Top of the dispatcher testbench: clock, reset, config writes and item stimulus.
// Depends on ttrd_pkg, ttrd_scoreboard and the dispatcher RTL.
module tb_timed_task_release_dispatcher;

  localparam logic [62:0] DUE_MAX = {63{1'b1}};
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [ttrd_pkg::IN_DW-1:0] in_tdata = '0;
  logic [1:0] in_tuser = ttrd_pkg::OP_INSERT;
  logic in_tready, out_tvalid, out_tlast, cfg_pready;
  logic [ttrd_pkg::OUT_DW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [5:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0, cfg_prdata;
  int fail_count, pending, cycles = 0;

  bit gaps_on = 1;       // random idle bursts on both channels
  bit long_hold = 0;     // request a long receiver stall
  logic [62:0] t_base;   // rolling time base so due times collide

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  timed_task_release_dispatcher dut (.*);

  ttrd_scoreboard chk (.*);

  // Cycle watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold so the table
  // backs up and the input stalls.
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 13);
        out_tready <= 0;
        repeat (hold) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic set_config(logic [2:0] gc, logic [63:0] k0, logic [63:0] k1,
                            logic [63:0] k2, logic [63:0] k3, logic [63:0] ms);
    reg_write(ttrd_pkg::REG_GROUP_COUNT, {61'd0, gc});
    reg_write(ttrd_pkg::REG_KEY0, k0);
    reg_write(ttrd_pkg::REG_KEY1, k1);
    reg_write(ttrd_pkg::REG_KEY2, k2);
    reg_write(ttrd_pkg::REG_KEY3, k3);
    reg_write(ttrd_pkg::REG_MAX_STAGE, ms);
  endtask

  // Hold the valid across back-to-back items; drop it only for a gap.
  task automatic send_item(logic [1:0] op, logic [15:0] tag, logic [62:0] due,
                           logic [63:0] where_m, logic [63:0] stage_m, logic [62:0] now);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {2'b00, now, stage_m, where_m, due, tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait for every expected result, then let the block finish its cleanup.
  task automatic drain();
    in_tvalid <= 0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Affinity / stage masks: zero, a low one-hot bit, or fully random.
  function automatic logic [63:0] rand_mask();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 64'd0;
    if (pick < 7) return 64'd1 << $urandom_range(0, 3);
    return rand64();
  endfunction

  task automatic random_items(int count);
    int op_pick;
    logic [62:0] due, now;
    for (int i = 0; i < count; i++) begin
      op_pick = $urandom_range(0, 99);
      due = ($urandom_range(0, 9) == 0) ? 63'(rand64()) : t_base + $urandom_range(0, 30);
      now = ($urandom_range(0, 9) == 0) ? 63'(rand64()) : t_base + $urandom_range(0, 30);
      if (op_pick < 45)
        send_item(ttrd_pkg::OP_INSERT, 16'($urandom), due, rand_mask(), rand_mask(),
                  63'(rand64()));
      else if (op_pick < 75) begin
        send_item(ttrd_pkg::OP_DISPATCH, 16'($urandom), 63'(rand64()), rand64(), rand64(),
                  now);
        t_base = t_base + $urandom_range(0, 8);
      end else if (op_pick < 85)
        send_item(ttrd_pkg::OP_START, 16'($urandom), 63'(rand64()), rand64(), rand64(),
                  63'(rand64()));
      else
        send_item(ttrd_pkg::OP_ADVANCE, 16'($urandom), 63'(rand64()), rand64(), rand64(),
                  63'(rand64()));
    end
  endtask

  initial begin
    t_base = 63'd100;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed: all groups live, overlapping keys, staging up to 4.
    set_config(3'd4, 64'd1, 64'd2, '1, 64'd0, 64'd4);
    send_item(ttrd_pkg::OP_ADVANCE, 16'h0, '0, '0, '0, '0);   // stage 0 stays 0
    send_item(ttrd_pkg::OP_START, 16'h0, '0, '0, '0, '0);
    for (int i = 0; i < 4; i++)                               // 1,2,4 then wrap to 1
      send_item(ttrd_pkg::OP_ADVANCE, 16'h0, '0, '0, '0, '0);
    send_item(ttrd_pkg::OP_INSERT, 16'hFFFF, DUE_MAX, '1, '1, DUE_MAX);
    send_item(ttrd_pkg::OP_INSERT, 16'h0001, DUE_MAX, '0, '0, '0); // bump wraps to zero
    send_item(ttrd_pkg::OP_INSERT, 16'h0002, 63'd0, 64'd1, 64'd2, '0); // zero taken
    send_item(ttrd_pkg::OP_INSERT, 16'h0003, 63'd5, 64'd2, '0, '0);
    send_item(ttrd_pkg::OP_INSERT, 16'h0004, 63'd5, 64'd8, '0, '0);  // matches only the all-ones key
    send_item(ttrd_pkg::OP_INSERT, 16'h0005, 63'd3, '0, 64'd4, '0);
    send_item(ttrd_pkg::OP_INSERT, 16'h0006, 63'd7, 64'd3, 64'd1, '0);
    send_item(ttrd_pkg::OP_INSERT, 16'h0007, 63'd9, '1, '0, '0);
    send_item(ttrd_pkg::OP_INSERT, 16'h0008, 63'd1, '0, '0, '0);     // table full
    send_item(ttrd_pkg::OP_DISPATCH, 16'h0, '0, '0, '0, 63'd0);
    send_item(ttrd_pkg::OP_DISPATCH, 16'h0, '0, '0, '0, 63'd6);
    send_item(ttrd_pkg::OP_ADVANCE, 16'h0, '0, '0, '0, '0);
    send_item(ttrd_pkg::OP_DISPATCH, 16'h0, '0, '0, '0, DUE_MAX);
    send_item(ttrd_pkg::OP_DISPATCH, 16'h0, '0, '0, '0, DUE_MAX);    // only tag 6 is left
    drain();

    // No groups at all, staging off: start leaves stage at zero.
    set_config(3'd0, '1, '1, '1, '1, 64'd0);
    send_item(ttrd_pkg::OP_START, 16'h0, '0, '0, '0, '0);
    long_hold = 1;
    random_items(45);
    drain();

    // Group count above the limit, widest stage.
    set_config(3'd7, 64'd1, 64'd2, 64'd4, 64'd8, 64'h8000_0000_0000_0000);
    random_items(50);
    drain();

    // Random keys and a small stage range; no idling from here on.
    set_config(3'($urandom_range(1, 4)), rand_mask(), rand_mask(), rand_mask(),
               rand_mask(), 64'd8);
    gaps_on = 0;
    random_items(55);
    drain();

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
